[hdl/bmp_rle_pkg.sv]
// Shared types, constants and helpers of the BMP RLE span decoder.
package bmp_rle_pkg;

   localparam int unsigned DIM_BITS   = 13;
   localparam int unsigned POS_BITS   = 12;
   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned SIZE_LIMIT = 4096;

   localparam int unsigned CSR_IDX_BITS  = 2;
   localparam int unsigned CSR_DATA_BITS = DIM_BITS;
   localparam int unsigned RSP_DATA_BITS = 2 * POS_BITS + 3 * BYTE_BITS;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_RLE4_MODE    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // escape codes after a zero count byte
   localparam logic [BYTE_BITS-1:0] ESC_END_LINE   = 8'd0;
   localparam logic [BYTE_BITS-1:0] ESC_END_BITMAP = 8'd1;
   localparam logic [BYTE_BITS-1:0] ESC_DELTA      = 8'd2;

   localparam logic [BYTE_BITS-1:0] NIBBLE_MASK = 8'h0f;

   typedef enum logic [2:0] {
      PH_COUNT  = 3'd0,
      PH_VALUE  = 3'd1,
      PH_ESCAPE = 3'd2,
      PH_DX     = 3'd3,
      PH_DY     = 3'd4,
      PH_ABS    = 3'd5,
      PH_PAD    = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SPAN      = 2'd0,
      KIND_END_LINE  = 2'd1,
      KIND_END_IMAGE = 2'd2
   } kind_type;

   typedef struct packed {
      logic                rle4_mode;
      logic [DIM_BITS-1:0] eff_width;
      logic [DIM_BITS-1:0] eff_height;
   } cfg_type;

   typedef struct packed {
      logic                 emit;
      kind_type             kind;
      logic [POS_BITS-1:0]  row;
      logic [POS_BITS-1:0]  column;
      logic [BYTE_BITS-1:0] span_length;
      logic [BYTE_BITS-1:0] first_index;
      logic [BYTE_BITS-1:0] second_index;
   } rsp_type;

   // zero counts as one, anything above the limit counts as the limit
   function automatic logic [DIM_BITS-1:0] limit_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v == '0) r = DIM_BITS'(1);
      else if (v > DIM_BITS'(SIZE_LIMIT)) r = DIM_BITS'(SIZE_LIMIT);
      return r;
   endfunction

endpackage

[hdl/bmp_rle_parser.sv]
// Parse state and combinational step logic of the BMP RLE span decoder.
module bmp_rle_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [bmp_rle_pkg::BYTE_BITS-1:0] data_byte,
   input  logic                          final_byte,
   input  bmp_rle_pkg::cfg_type          cfg,
   output bmp_rle_pkg::rsp_type          result
);
   import bmp_rle_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [BYTE_BITS-1:0] pending_count_ff, pending_count_in;
   logic [BYTE_BITS-1:0] absolute_left_ff, absolute_left_in;
   logic                 pad_pending_ff, pad_pending_in;
   logic [BYTE_BITS-1:0] delta_dx_ff, delta_dx_in;
   logic [DIM_BITS-1:0]  column_pos_ff, column_pos_in;
   logic [DIM_BITS-1:0]  line_pos_ff, line_pos_in;
   logic                 finished_ff, finished_in;

   logic [BYTE_BITS-1:0] idx_a, idx_b;
   logic [DIM_BITS-1:0]  row_val, room;
   logic [BYTE_BITS-1:0] abs_px, span_req, span_len;
   logic [DIM_BITS:0]    line_inc, col_delta, line_delta;
   logic [BYTE_BITS:0]   nib_bytes;

   assign idx_a = cfg.rle4_mode ? {4'b0, data_byte[7:4]} : data_byte;
   assign idx_b = cfg.rle4_mode ? (data_byte & NIBBLE_MASK) : data_byte;

   assign row_val = (line_pos_ff < cfg.eff_height) ?
                    (cfg.eff_height - DIM_BITS'(1) - line_pos_ff) : '0;
   assign room    = (column_pos_ff < cfg.eff_width) ? (cfg.eff_width - column_pos_ff) : '0;

   assign abs_px   = (cfg.rle4_mode && absolute_left_ff >= BYTE_BITS'(2)) ? BYTE_BITS'(2) :
                     (absolute_left_ff != '0 ? BYTE_BITS'(1) : '0);
   assign span_req = (phase_ff == PH_ABS) ? abs_px : pending_count_ff;
   assign span_len = ({{(DIM_BITS-BYTE_BITS){1'b0}}, span_req} < room) ?
                     span_req : room[BYTE_BITS-1:0];

   assign line_inc   = {1'b0, line_pos_ff} + (DIM_BITS+1)'(1);
   assign col_delta  = {1'b0, column_pos_ff} + {{(DIM_BITS+1-BYTE_BITS){1'b0}}, delta_dx_ff};
   assign line_delta = {1'b0, line_pos_ff} + {{(DIM_BITS+1-BYTE_BITS){1'b0}}, data_byte};
   assign nib_bytes  = cfg.rle4_mode ? (({1'b0, data_byte} + (BYTE_BITS+1)'(1)) >> 1)
                                     : {1'b0, data_byte};

   always_comb begin
      phase_in         = phase_ff;
      pending_count_in = pending_count_ff;
      absolute_left_in = absolute_left_ff;
      pad_pending_in   = pad_pending_ff;
      delta_dx_in      = delta_dx_ff;
      column_pos_in    = column_pos_ff;
      line_pos_in      = line_pos_ff;
      finished_in      = finished_ff;
      result           = '0;
      result.kind      = KIND_SPAN;

      // span fields, used when a span goes out
      result.row          = row_val[POS_BITS-1:0];
      result.column       = column_pos_ff[POS_BITS-1:0];
      result.span_length  = span_len;
      result.first_index  = idx_a;
      result.second_index = (span_len == BYTE_BITS'(1)) ? idx_a : idx_b;

      unique case (phase_ff)
         PH_COUNT: begin
            if (data_byte == '0) begin
               phase_in = PH_ESCAPE;
            end else begin
               pending_count_in = data_byte;
               phase_in         = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (span_len != '0) begin
               result.emit   = 1'b1;
               column_pos_in = column_pos_ff + {{(DIM_BITS-BYTE_BITS){1'b0}}, span_len};
            end
            phase_in = PH_COUNT;
         end
         PH_ESCAPE: begin
            phase_in = PH_COUNT;
            if (data_byte == ESC_END_LINE) begin
               column_pos_in = '0;
               result.emit   = 1'b1;
               result.column = '0;
               result.span_length  = '0;
               result.first_index  = '0;
               result.second_index = '0;
               if (line_inc >= {1'b0, cfg.eff_height}) begin
                  line_pos_in = cfg.eff_height;
                  finished_in = 1'b1;
                  result.kind = KIND_END_IMAGE;
                  result.row  = '0;
               end else begin
                  line_pos_in = line_inc[DIM_BITS-1:0];
                  result.kind = KIND_END_LINE;
               end
            end else if (data_byte == ESC_END_BITMAP) begin
               finished_in = 1'b1;
               result      = '0;
               result.emit = 1'b1;
               result.kind = KIND_END_IMAGE;
            end else if (data_byte == ESC_DELTA) begin
               phase_in = PH_DX;
            end else begin
               absolute_left_in = data_byte;
               pad_pending_in   = nib_bytes[0];
               phase_in         = PH_ABS;
            end
         end
         PH_DX: begin
            delta_dx_in = data_byte;
            phase_in    = PH_DY;
         end
         PH_DY: begin
            // clamp after the add
            column_pos_in = (col_delta >= {1'b0, cfg.eff_width}) ?
                            (cfg.eff_width - DIM_BITS'(1)) : col_delta[DIM_BITS-1:0];
            line_pos_in   = (line_delta >= {1'b0, cfg.eff_height}) ?
                            (cfg.eff_height - DIM_BITS'(1)) : line_delta[DIM_BITS-1:0];
            phase_in      = PH_COUNT;
         end
         PH_ABS: begin
            if (span_len != '0) begin
               result.emit   = 1'b1;
               column_pos_in = column_pos_ff + {{(DIM_BITS-BYTE_BITS){1'b0}}, span_len};
            end
            absolute_left_in = absolute_left_ff - abs_px;
            if (absolute_left_ff == abs_px) begin
               phase_in = pad_pending_ff ? PH_PAD : PH_COUNT;
            end
         end
         PH_PAD: begin
            pad_pending_in = 1'b0;
            phase_in       = PH_COUNT;
         end
         default: begin
            phase_in = PH_COUNT;
         end
      endcase

      if (final_byte) finished_in = 1'b1;

      // once finished, drop every byte
      if (finished_ff) begin
         phase_in         = phase_ff;
         pending_count_in = pending_count_ff;
         absolute_left_in = absolute_left_ff;
         pad_pending_in   = pad_pending_ff;
         delta_dx_in      = delta_dx_ff;
         column_pos_in    = column_pos_ff;
         line_pos_in      = line_pos_ff;
         finished_in      = 1'b1;
         result.emit      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_COUNT;
         pending_count_ff <= '0;
         absolute_left_ff <= '0;
         pad_pending_ff   <= 1'b0;
         delta_dx_ff      <= '0;
         column_pos_ff    <= '0;
         line_pos_ff      <= '0;
         finished_ff      <= 1'b0;
      end else if (step) begin
         phase_ff         <= phase_in;
         pending_count_ff <= pending_count_in;
         absolute_left_ff <= absolute_left_in;
         pad_pending_ff   <= pad_pending_in;
         delta_dx_ff      <= delta_dx_in;
         column_pos_ff    <= column_pos_in;
         line_pos_ff      <= line_pos_in;
         finished_ff      <= finished_in;
      end
   end

endmodule

[hdl/bmp_rle_span_decoder_unit.sv]
// Top level of the BMP RLE8/RLE4 span decoder: request, response and config registers.
// A request byte taken into the request register passes through the parse step into the
//   response register, unless a held response keeps it waiting in the request register.
// Throughput: one request byte per cycle, set by the combinational parse step between the
//   request and response registers; a held response stalls the request side.
// Reset (synchronous, active high) empties both registers; parse restarts at line 0, RLE8, 1x1.
module bmp_rle_span_decoder_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [bmp_rle_pkg::BYTE_BITS-1:0]       req_tdata,  // [7:0] data_byte
   input  logic                                    req_tlast,  // final_byte
   // response channel
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [11:0] row, [23:12] column, [31:24] span_length,
   // [39:32] first_index, [47:40] second_index
   output logic [bmp_rle_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic [1:0]                              rsp_tuser,  // [1:0] kind
   // configuration write port
   input  logic                                    csr_we,
   input  logic [bmp_rle_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bmp_rle_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import bmp_rle_pkg::*;

   // request register
   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0] in_data_ff;
   logic                 in_last_ff;

   // response register
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff;

   // configuration, held already limited to the legal size range
   logic                 rle4_mode_ff;
   logic [DIM_BITS-1:0]  eff_width_ff;
   logic [DIM_BITS-1:0]  eff_height_ff;

   cfg_type              cfg;
   rsp_type              step_result;
   logic                 advance;

   // advance the held byte whenever the response register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? step_result.emit : (out_valid_ff && !rsp_tready);

   assign cfg.rle4_mode  = rle4_mode_ff;
   assign cfg.eff_width  = eff_width_ff;
   assign cfg.eff_height = eff_height_ff;

   bmp_rle_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_data_ff),
      .final_byte (in_last_ff),
      .cfg        (cfg),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payloads: load a new byte on acceptance, hold the response until taken
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   // configuration writes; sizes are limited on the way in
   always_ff @(posedge clock) begin
      if (reset) begin
         rle4_mode_ff  <= 1'b0;
         eff_width_ff  <= DIM_BITS'(1);
         eff_height_ff <= DIM_BITS'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RLE4_MODE:    rle4_mode_ff  <= csr_wdata[0];
            CSR_IMAGE_WIDTH:  eff_width_ff  <= limit_dim(csr_wdata);
            CSR_IMAGE_HEIGHT: eff_height_ff <= limit_dim(csr_wdata);
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {out_ff.second_index, out_ff.first_index, out_ff.span_length,
                        out_ff.column, out_ff.row};

endmodule

[test/bmp_rle_span_decoder_unit_tb.sv]
// Self-checking testbench for the BMP RLE8/RLE4 span decoder unit.
`timescale 1ns / 1ps

module bmp_rle_span_decoder_unit_tb;
   import bmp_rle_pkg::*;

   localparam int unsigned STALL_LIMIT  = 3000;  // cycles with no handshake at all
   localparam int unsigned SETTLE_TICKS = 4;     // request register plus response register
   localparam int unsigned LONG_HOLD    = 400;   // receiver hold-off that backs up the input
   localparam int unsigned MAX_REPORTS  = 25;

   // opening stimulus in RLE8 on a 4096 x 4096 image: longest run, absolute run with its
   // pad byte, the largest delta and an end of line
   localparam logic [7:0] RLE8_OPENING [14] = '{
      8'hff, 8'hff,
      8'h00, 8'h03, 8'haa, 8'h55, 8'hc3, 8'h00,
      8'h00, ESC_DELTA, 8'hff, 8'hff,
      8'h00, ESC_END_LINE
   };
   // opening stimulus in RLE4 on a 5-pixel line: clipped run, absolute run lying wholly
   // past the line end (consumed, nothing written), end of line, single-pixel run
   localparam logic [7:0] RLE4_OPENING [12] = '{
      8'h07, 8'ha5,
      8'h00, 8'h05, 8'h12, 8'h34, 8'h56, 8'h00,
      8'h00, ESC_END_LINE,
      8'h01, 8'hf0
   };

   typedef struct {
      kind_type             kind;
      logic [POS_BITS-1:0]  row;
      logic [POS_BITS-1:0]  column;
      logic [BYTE_BITS-1:0] span_length;
      logic [BYTE_BITS-1:0] first_index;
      logic [BYTE_BITS-1:0] second_index;
   } span_write_type;

   typedef struct {
      logic                rle4;
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
      int unsigned         items;
      bit                  steady;  // no idling on either side
      bit                  hold;    // long receiver hold-off during this stretch
   } setup_type;

   // Span predictor and scoreboard: mirrors the parser state, queues the writes each
   // accepted byte should produce and checks responses against them in order.
   class span_scoreboard;
      logic                 rle4_on;
      logic [DIM_BITS-1:0]  width_reg;
      logic [DIM_BITS-1:0]  height_reg;
      phase_type            phase;
      logic [BYTE_BITS-1:0] run_count;
      logic [BYTE_BITS-1:0] abs_left;
      logic [BYTE_BITS-1:0] delta_col;
      logic                 pad_due;
      logic [DIM_BITS-1:0]  col_pos;
      logic [DIM_BITS-1:0]  line_pos;
      bit                   done;
      span_write_type       expected_writes [$];
      int unsigned          errors;

      function new();
         rle4_on    = 1'b0;
         width_reg  = 13'd1;
         height_reg = 13'd1;
         phase      = PH_COUNT;
         run_count  = '0;
         abs_left   = '0;
         delta_col  = '0;
         pad_due    = 1'b0;
         col_pos    = '0;
         line_pos   = '0;
         done       = 1'b0;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_RLE4_MODE:    rle4_on = value[0];
            CSR_IMAGE_WIDTH:  width_reg = value;
            CSR_IMAGE_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      // zero reads as one, anything past the buffer reads as the buffer size
      function int unsigned eff_dim(logic [DIM_BITS-1:0] v);
         if (v == '0) return 1;
         if (v > 13'd4096) return 4096;
         return 32'(v);
      endfunction

      function bit at_last_line();
         return 32'(line_pos) + 1 >= eff_dim(height_reg);
      endfunction

      function logic [POS_BITS-1:0] cur_row();
         int unsigned h;
         h = eff_dim(height_reg);
         if (32'(line_pos) < h) return POS_BITS'(h - 1 - 32'(line_pos));
         return '0;
      endfunction

      function void push_mark(kind_type k, logic [POS_BITS-1:0] r);
         span_write_type s;
         s.kind = k;
         s.row = r;
         s.column = '0;
         s.span_length = '0;
         s.first_index = '0;
         s.second_index = '0;
         expected_writes.push_back(s);
      endfunction

      function void push_span(int unsigned n, logic [7:0] a, logic [7:0] b);
         int unsigned w, room, len;
         span_write_type s;
         w = eff_dim(width_reg);
         room = (32'(col_pos) < w) ? w - 32'(col_pos) : 0;
         len = (n < room) ? n : room;
         if (len == 0) return;
         if (len == 1) b = a;
         s.kind = KIND_SPAN;
         s.row = cur_row();
         s.column = col_pos[POS_BITS-1:0];
         s.span_length = BYTE_BITS'(len);
         s.first_index = a;
         s.second_index = b;
         expected_writes.push_back(s);
         col_pos = col_pos + DIM_BITS'(len);
      endfunction

      function void take_byte(logic [7:0] b, logic last);
         logic [8:0]  nbytes;
         int unsigned px, c, l, w, h;
         if (done) return;
         w = eff_dim(width_reg);
         h = eff_dim(height_reg);
         case (phase)
            PH_COUNT: begin
               if (b == 8'h00) phase = PH_ESCAPE;
               else begin
                  run_count = b;
                  phase = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (rle4_on) push_span(32'(run_count), b >> 4, b & NIBBLE_MASK);
               else push_span(32'(run_count), b, b);
               phase = PH_COUNT;
            end
            PH_ESCAPE: begin
               phase = PH_COUNT;
               if (b == ESC_END_LINE) begin
                  c = 32'(cur_row());
                  col_pos = '0;
                  if (at_last_line()) begin
                     line_pos = DIM_BITS'(h);
                     done = 1'b1;
                     push_mark(KIND_END_IMAGE, '0);
                  end else begin
                     line_pos = line_pos + 13'd1;
                     push_mark(KIND_END_LINE, POS_BITS'(c));
                  end
               end else if (b == ESC_END_BITMAP) begin
                  done = 1'b1;
                  push_mark(KIND_END_IMAGE, '0);
               end else if (b == ESC_DELTA) begin
                  phase = PH_DX;
               end else begin
                  nbytes = rle4_on ? ({1'b0, b} + 9'd1) >> 1 : {1'b0, b};
                  abs_left = b;
                  pad_due = nbytes[0];
                  phase = PH_ABS;
               end
            end
            PH_DX: begin
               delta_col = b;
               phase = PH_DY;
            end
            PH_DY: begin
               c = 32'(col_pos) + 32'(delta_col);
               l = 32'(line_pos) + 32'(b);
               if (c >= w) c = w - 1;
               if (l >= h) l = h - 1;
               col_pos = DIM_BITS'(c);
               line_pos = DIM_BITS'(l);
               phase = PH_COUNT;
            end
            PH_ABS: begin
               px = rle4_on ? 2 : 1;
               if (px > 32'(abs_left)) px = 32'(abs_left);
               if (rle4_on) push_span(px, b >> 4, b & NIBBLE_MASK);
               else push_span(px, b, b);
               abs_left = abs_left - BYTE_BITS'(px);
               if (abs_left == '0) phase = pad_due ? PH_PAD : PH_COUNT;
            end
            PH_PAD: begin
               pad_due = 1'b0;
               phase = PH_COUNT;
            end
            default: phase = PH_COUNT;
         endcase
         if (last) done = 1'b1;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
      endtask

      task check_write(span_write_type got);
         span_write_type want;
         if (expected_writes.size() == 0) begin
            report($sformatf("response kind %0d with nothing pending", got.kind));
            return;
         end
         want = expected_writes.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
         if (got.row !== want.row)
            report($sformatf("row %0d, wanted %0d", got.row, want.row));
         if (got.column !== want.column)
            report($sformatf("column %0d, wanted %0d", got.column, want.column));
         if (got.span_length !== want.span_length)
            report($sformatf("span length %0d, wanted %0d", got.span_length,
                             want.span_length));
         if (got.first_index !== want.first_index)
            report($sformatf("first index %0h, wanted %0h", got.first_index,
                             want.first_index));
         if (got.second_index !== want.second_index)
            report($sformatf("second index %0h, wanted %0h", got.second_index,
                             want.second_index));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [BYTE_BITS-1:0]     req_tdata = '0;   // [7:0] data_byte
   logic                     req_tlast = 1'b0; // final_byte
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // row, column, span_length, first, second
   logic [1:0]               rsp_tuser;        // [1:0] kind
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   span_scoreboard sb;
   bit             steady = 1'b0;    // both sides run without idling
   bit             hold_rsp = 1'b0;  // ask the receiver for one long hold-off
   setup_type      plan [10];

   bmp_rle_span_decoder_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // gap lengths: mostly short, now and then long
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned sender_gap();
      if (steady || $urandom_range(0, 99) < 75) return 0;
      return pick_gap();
   endfunction

   // Choose the next byte from the parse phase the stream has reached, so that most of
   // the stream is well formed with random content. A small share is pure noise. Never
   // finish the image early: end of bitmap, and end of line on the last line, turn
   // into a delta instead.
   function automatic logic [7:0] pick_byte();
      int unsigned r;
      logic [7:0]  b;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) b = 8'($urandom_range(0, 255));
      else begin
         case (sb.phase)
            PH_COUNT: begin
               if (r < 30) b = 8'h00;
               else if (r < 65) b = 8'($urandom_range(1, 8));
               else if (r < 88) b = 8'($urandom_range(9, 64));
               else b = 8'($urandom_range(65, 255));
            end
            PH_ESCAPE: begin
               if (r < 40 && !sb.at_last_line()) b = ESC_END_LINE;
               else if (r < 60) b = ESC_DELTA;
               else if (r < 95) b = 8'($urandom_range(3, 12));
               else b = 8'($urandom_range(13, 255));
            end
            PH_DX: b = (r < 90) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(8, 255));
            PH_DY: begin
               if (r < 50) b = 8'h00;
               else if (r < 90) b = 8'($urandom_range(1, 3));
               else b = 8'($urandom_range(4, 255));
            end
            default: b = 8'($urandom_range(0, 255));
         endcase
      end
      if (sb.phase == PH_ESCAPE &&
          (b == ESC_END_BITMAP || (b == ESC_END_LINE && sb.at_last_line())))
         b = ESC_DELTA;
      return b;
   endfunction

   // Offer one request and hold it until taken; note it with the predictor on the
   // accepting edge, then idle for a random gap. Call at a rising edge.
   task automatic push_byte(input logic [7:0] d, input logic last);
      int unsigned g;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.take_byte(d, last);
      g = sender_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Write all three registers back to back; only while the decoder is idle.
   task automatic apply_setup(input logic m, input logic [12:0] w, input logic [12:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_RLE4_MODE;
      csr_wdata <= {12'd0, m};
      sb.set_reg(CSR_RLE4_MODE, {12'd0, m});
      @(posedge clock);
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      sb.set_reg(CSR_IMAGE_WIDTH, w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      sb.set_reg(CSR_IMAGE_HEIGHT, h);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drop valid, wait for every pending write to come back, then give the block time
   // to finish a byte that produces nothing.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin : rsp_side
      int unsigned gap_left;
      gap_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            gap_left = LONG_HOLD;
         end
         if (gap_left > 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else if (steady || $urandom_range(0, 99) < 75) begin
            rsp_tready <= 1'b1;
         end else begin
            gap_left = pick_gap();
            rsp_tready <= 1'b0;
         end
      end
   end

   // check every accepted response against the oldest pending write
   always @(posedge clock) begin
      span_write_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = kind_type'(rsp_tuser);
         got.row = rsp_tdata[11:0];
         got.column = rsp_tdata[23:12];
         got.span_length = rsp_tdata[31:24];
         got.first_index = rsp_tdata[39:32];
         got.second_index = rsp_tdata[47:40];
         sb.check_write(got);
      end
   end

   // end the run when nothing has moved for far longer than any correct stall
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned p, n;
      logic [12:0] h_last;
      sb = new();
      // mode, width, height, requests, steady, hold; extremes and out-of-range sizes
      // included, plus heights that shrink below the line reached so far
      plan = '{
         '{1'b0, 13'd16,   13'd4096, 250, 1'b0, 1'b0},
         '{1'b1, 13'd16,   13'd4096, 250, 1'b1, 1'b0},
         '{1'b1, 13'd0,    13'd5000, 150, 1'b0, 1'b0},
         '{1'b0, 13'd8191, 13'd4096, 200, 1'b0, 1'b1},
         '{1'b0, 13'd7,    13'd2,    150, 1'b0, 1'b0},
         '{1'b1, 13'd33,   13'd4096, 250, 1'b0, 1'b0},
         '{1'b0, 13'd100,  13'd3,    200, 1'b0, 1'b0},
         '{1'b1, 13'd4096, 13'd4096, 250, 1'b0, 1'b0},
         '{1'b0, 13'd12,   13'd0,    100, 1'b1, 1'b0},
         '{1'b1, 13'd20,   13'd4096, 150, 1'b0, 1'b0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening
      apply_setup(1'b0, 13'd4096, 13'd4096);
      foreach (RLE8_OPENING[i]) push_byte(RLE8_OPENING[i], 1'b0);
      drain();
      apply_setup(1'b1, 13'd5, 13'd8191);
      foreach (RLE4_OPENING[i]) push_byte(RLE4_OPENING[i], 1'b0);
      drain();

      // random stretches, each under its own setting; the sender waits for every
      // pending write before the registers change
      for (p = 0; p < 10; p++) begin
         apply_setup(plan[p].rle4, plan[p].width, plan[p].height);
         steady = plan[p].steady;
         if (plan[p].hold) hold_rsp = 1'b1;
         for (n = 0; n < plan[p].items; n++) push_byte(pick_byte(), 1'b0);
         drain();
      end
      steady = 1'b0;

      // finish the image one of three ways, on a height a few lines below the current
      // line, and mark the closing byte as the last of the source
      h_last = (32'(sb.line_pos) + 3 > 4096) ? 13'd4096
                                             : sb.line_pos + 13'($urandom_range(1, 3));
      apply_setup(1'($urandom_range(0, 1)), 13'd64, h_last);
      while (sb.phase != PH_COUNT) push_byte(pick_byte(), 1'b0);
      case ($urandom_range(0, 2))
         0: begin
            push_byte(8'h00, 1'b0);
            push_byte(ESC_END_BITMAP, 1'b1);
         end
         1: begin
            while (!sb.done)
               push_byte(ESC_END_LINE, sb.phase == PH_ESCAPE && sb.at_last_line());
         end
         default: begin
            repeat ($urandom_range(5, 30)) push_byte(pick_byte(), 1'b0);
            push_byte(pick_byte(), 1'b1);
         end
      endcase
      // bytes after the finish must be swallowed without a response
      repeat (8) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_tvalid <= 1'b0;

      while (sb.expected_writes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
